/* hw/rtl/trailing_window_std_dev_top_assert.svh */
// Assertion macros for the trailing window statistics block.
// Each macro expects clk and rst_n in scope.
`ifndef TRAILING_WINDOW_STD_DEV_TOP_ASSERT_SVH
`define TRAILING_WINDOW_STD_DEV_TOP_ASSERT_SVH
`ifndef SYNTH
`define TWD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twd assertion failed");
`define TWD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twd assertion failed");
`else
`define TWD_ASSERT_IMP(lbl, ante, cons)
`define TWD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/twd_pkg.sv */
package twd_pkg;

  // Fixed field widths of the ports.
  localparam int CH_BITS   = 2;
  localparam int N_BITS    = 7;
  localparam int OUT_BITS  = 32;

  // Window length after reset.
  localparam logic [N_BITS-1:0] WIN_RESET = 7'd25;
  localparam int WIN_MIN = 2;

  // n*(n-1) for n up to 127 fits in 14 bits.
  localparam int DEN_BITS = 14;

  // Fixed point scaling: mean carries 8 fraction bits, the variance 16.
  localparam int MEAN_SHIFT = 8;
  localparam int FRAC_BITS  = 16;

  // Square root works on a 64 bit radicand and yields 32 bits.
  localparam int RAD_BITS  = 64;
  localparam int ROOT_BITS = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic acc_start;
    logic mdiv_start;
    logic vdiv_start;
    logic sqrt_start;
    logic mean_latch;
    logic out_load;
  } twd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_ok;
    logic acc_busy;
    logic div_busy;
    logic sqrt_busy;
  } twd_sts_t;

endpackage

/* hw/rtl/twd_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
module twd_div #(
  parameter int W = 78
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [W-1:0]                   dividend,
  input  logic [$clog2(W+1)-1:0]         steps,
  input  logic [twd_pkg::DEN_BITS-1:0]   divisor,
  output logic                           busy,
  output logic [W-1:0]                   quo,
  output logic [twd_pkg::DEN_BITS-1:0]   rem
);

  localparam int DB  = twd_pkg::DEN_BITS;
  localparam int STW = $clog2(W+1);

  logic [STW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [DB-1:0]  rem_r, rem_nxt;
  logic [DB-1:0]  div_r;
  logic [DB:0]    trial;
  logic           ge;

  // One shift and trial subtract per step.
  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? DB'(trial - {1'b0, div_r}) : DB'(trial);
    quo_nxt = {quo_r[W-2:0], ge};
    cnt_nxt = cnt_r - STW'(1);
  end

  // Step counter is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Operand registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/twd_dpath.sv */
// Datapath: sample rings, window accumulation, divisions and square root.
module twd_dpath #(
  parameter int CHANNELS    = 3,
  parameter int RING_DEPTH  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [twd_pkg::N_BITS-1:0]            cfg_wr_data,
  input  logic [twd_pkg::CH_BITS-1:0]           in_channel,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  twd_pkg::twd_cmd_t                     cmd,
  output twd_pkg::twd_sts_t                     sts,
  output logic [twd_pkg::CH_BITS-1:0]           out_channel,
  output logic [twd_pkg::N_BITS-1:0]            out_used_count,
  output logic signed [twd_pkg::OUT_BITS-1:0]   out_mean_q8,
  output logic [twd_pkg::OUT_BITS-1:0]          out_std_dev_q8
);

  localparam int NB    = twd_pkg::N_BITS;
  localparam int CB    = twd_pkg::CH_BITS;
  localparam int DB    = twd_pkg::DEN_BITS;
  localparam int OB    = twd_pkg::OUT_BITS;
  localparam int RB    = twd_pkg::RAD_BITS;
  localparam int TB    = twd_pkg::ROOT_BITS;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(RING_DEPTH);
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int DEPTH = CHANNELS * RING_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = SAMPLE_BITS + NB;
  localparam int SQW   = 2 * SAMPLE_BITS;
  localparam int SSW   = SQW + NB;
  localparam int DW    = SSW + NB;
  localparam int MW    = SUMW + twd_pkg::MEAN_SHIFT;
  localparam int QW    = DW + twd_pkg::FRAC_BITS;
  localparam int STW   = $clog2(QW + 1);
  localparam int MEW   = (MW + 1 > 34) ? MW + 1 : 34;
  localparam int SCW   = $clog2(TB + 1);

  // Configuration and per-channel ring state.
  logic [NB-1:0]               win_r;
  logic [PW-1:0]               wp_r   [CHANNELS];
  logic [FW-1:0]               fill_r [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];

  // Item registers.
  logic [CB-1:0]  ch_r;
  logic [NB-1:0]  n_r;
  logic           ok_r;
  logic [AW-1:0]  base_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [DB-1:0]  den_r;

  // Take path.
  logic           ch_ok;
  logic [CW-1:0]  ch_idx;
  logic [FW-1:0]  fill_cur, fill_new;
  logic [PW-1:0]  wp_cur, wp_new;
  logic [31:0]    win_c, n_c;
  logic [NB-1:0]  n_take;
  logic [AW-1:0]  wr_addr, rd_addr;

  // Accumulation pipeline.
  logic [NB-1:0]                 cnt_r;
  logic                          rd_v_r, sq_v_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r, s_r;
  logic signed [SQW-1:0]         sq_full;
  logic [SQW-1:0]                sq_r;
  logic signed [SUMW-1:0]        sum_r;
  logic [SSW-1:0]                sumsq_r;

  // Variance numerator.
  logic [SUMW-1:0] mag_r;
  logic [DW-1:0]   prod1_r, prod2_r, d_r;

  // Division.
  logic            div_start;
  logic [QW-1:0]   div_dividend, div_quo;
  logic [STW-1:0]  div_steps;
  logic [DB-1:0]   div_divisor, div_rem;
  logic            div_busy;

  // Mean result.
  logic            neg;
  logic [MEW-1:0]  q_mag, neg_mag;
  logic [OB-1:0]   mean_nxt, mean_r;

  // Square root.
  logic [SCW-1:0]  sq_cnt_r;
  logic [RB-1:0]   vsh_r, rad;
  logic [TB+1:0]   srem_r;
  logic [TB-1:0]   root_r;
  logic [TB+3:0]   rem2, strial;
  logic            rad_sat;

  // Output registers.
  logic [CB-1:0]         out_ch_r;
  logic [NB-1:0]         out_n_r;
  logic [OB-1:0]         out_mean_r, out_sd_r;

  // Sample update and window size for the arriving word.
  always_comb begin
    ch_ok    = (32'(in_channel) < CHANNELS);
    ch_idx   = CW'(in_channel);
    fill_cur = fill_r[ch_idx];
    fill_new = (32'(fill_cur) == RING_DEPTH) ? fill_cur : fill_cur + FW'(1);
    wp_cur   = wp_r[ch_idx];
    wp_new   = (32'(wp_cur) == RING_DEPTH - 1) ? '0 : wp_cur + PW'(1);
    if (32'(win_r) < twd_pkg::WIN_MIN) begin
      win_c = 32'(twd_pkg::WIN_MIN);
    end else if (32'(win_r) > RING_DEPTH) begin
      win_c = 32'(RING_DEPTH);
    end else begin
      win_c = 32'(win_r);
    end
    n_c     = (32'(fill_new) < win_c) ? 32'(fill_new) : win_c;
    n_take  = ch_ok ? NB'(n_c) : '0;
    wr_addr = AW'(32'(ch_idx) * RING_DEPTH + 32'(wp_cur));
    rd_addr = base_r + AW'(rd_ptr_r);
  end

  // Configuration register and ring pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= twd_pkg::WIN_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (cmd.take && ch_ok) begin
        wp_r[ch_idx]   <= wp_new;
        fill_r[ch_idx] <= fill_new;
      end
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take && ch_ok) begin
      ring_mem[wr_addr] <= in_sample;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // Item registers captured when a word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (cmd.take) begin
      ok_r <= ch_ok && (n_c >= 32'(twd_pkg::WIN_MIN));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r   <= in_channel;
      n_r    <= n_take;
      base_r <= AW'(32'(ch_idx) * RING_DEPTH);
      den_r  <= DB'(n_take) * DB'(n_take - NB'(1));
    end
  end

  // Read walk: newest entry first, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= rd_v_r;
      if (cmd.acc_start) begin
        cnt_r  <= n_r;
        rd_v_r <= 1'b0;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - NB'(1);
        rd_v_r <= 1'b1;
      end else begin
        rd_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_ptr_r <= wp_cur;
    end else if (cnt_r != '0) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? PW'(RING_DEPTH - 1) : rd_ptr_r - PW'(1);
    end
  end

  // Square stage and accumulators.
  assign sq_full = rd_data_r * rd_data_r;

  always_ff @(posedge clk) begin
    s_r  <= rd_data_r;
    sq_r <= $unsigned(sq_full);
    if (cmd.acc_start) begin
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (sq_v_r) begin
      sum_r   <= sum_r + SUMW'(s_r);
      sumsq_r <= sumsq_r + SSW'(sq_r);
    end
  end

  // Numerator n*sumsq - sum^2, one multiplication per register stage.
  always_ff @(posedge clk) begin
    mag_r   <= sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
    prod1_r <= DW'(sumsq_r) * DW'(n_r);
    prod2_r <= DW'(mag_r) * DW'(mag_r);
    d_r     <= prod1_r - prod2_r;
  end

  // Shared divider: first 256*|sum| by n, then 65536*d by n*(n-1).
  assign div_start = cmd.mdiv_start || cmd.vdiv_start;

  always_comb begin
    if (cmd.mdiv_start) begin
      div_dividend = QW'({mag_r, {twd_pkg::MEAN_SHIFT{1'b0}}}) << (QW - MW);
      div_steps    = STW'(MW);
      div_divisor  = DB'(n_r);
    end else begin
      div_dividend = {d_r, {twd_pkg::FRAC_BITS{1'b0}}};
      div_steps    = STW'(QW);
      div_divisor  = den_r;
    end
  end

  twd_div #(
    .W (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .steps    (div_steps),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Floor of the signed mean, saturated to 32 bits.
  always_comb begin
    neg     = sum_r[SUMW-1];
    q_mag   = MEW'(div_quo[MW-1:0]) + MEW'(neg && (div_rem != '0));
    neg_mag = -q_mag;
    if (!neg) begin
      mean_nxt = (q_mag > MEW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_mag[OB-1:0];
    end else begin
      mean_nxt = (q_mag > MEW'(32'h8000_0000)) ? 32'h8000_0000 : neg_mag[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_latch) begin
      mean_r <= mean_nxt;
    end
  end

  // Square root, two radicand bits per step.
  always_comb begin
    rad_sat = ((div_quo >> (RB - 1)) != '0);
    rad     = rad_sat ? '1 : RB'(div_quo);
    rem2    = {srem_r, vsh_r[RB-1:RB-2]};
    strial  = {2'b00, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (cmd.sqrt_start) begin
      sq_cnt_r <= SCW'(TB);
    end else if (sq_cnt_r != '0) begin
      sq_cnt_r <= sq_cnt_r - SCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      vsh_r  <= rad;
      srem_r <= '0;
      root_r <= '0;
    end else if (sq_cnt_r != '0) begin
      vsh_r <= {vsh_r[RB-3:0], 2'b00};
      if (rem2 >= strial) begin
        srem_r <= (TB+2)'(rem2 - strial);
        root_r <= {root_r[TB-2:0], 1'b1};
      end else begin
        srem_r <= (TB+2)'(rem2);
        root_r <= {root_r[TB-2:0], 1'b0};
      end
    end
  end

  // Result word; statistics read as zero when the window is too short.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_n_r    <= n_r;
      out_mean_r <= ok_r ? mean_r : '0;
      out_sd_r   <= ok_r ? root_r : '0;
    end
  end

  assign out_channel    = out_ch_r;
  assign out_used_count = out_n_r;
  assign out_mean_q8    = $signed(out_mean_r);
  assign out_std_dev_q8 = out_sd_r;

  assign sts.item_ok   = ok_r;
  assign sts.acc_busy  = (cnt_r != '0) || rd_v_r || sq_v_r;
  assign sts.div_busy  = div_busy;
  assign sts.sqrt_busy = (sq_cnt_r != '0);

endmodule

/* hw/rtl/twd_ctrl.sv */
// Controller: sequences one word through the datapath at a time.
module twd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  twd_pkg::twd_sts_t   sts,
  output twd_pkg::twd_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ACC,
    S_MDIV_GO,
    S_MDIV_WAIT,
    S_VDIV_GO,
    S_VDIV_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.take     = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.item_ok) begin
          cmd.acc_start = 1'b1;
          state_nxt     = S_ACC;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_ACC: begin
        if (!sts.acc_busy) begin
          state_nxt = S_MDIV_GO;
        end
      end
      S_MDIV_GO: begin
        cmd.mdiv_start = 1'b1;
        state_nxt      = S_MDIV_WAIT;
      end
      S_MDIV_WAIT: begin
        if (!sts.div_busy) begin
          cmd.mean_latch = 1'b1;
          state_nxt      = S_VDIV_GO;
        end
      end
      S_VDIV_GO: begin
        cmd.vdiv_start = 1'b1;
        state_nxt      = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/trailing_window_std_dev_top.sv */
// Each word runs the window walk (one ring read per cycle), the bit-serial divider
// (used twice, for the mean and the variance) and the 32 step square root in turn;
// when n is below 2 it goes straight to the result word. One word is in flight at a
// time: the next word is taken only once the result word is loaded.
// Reset (rst_n, synchronous, active low) clears pointers and fill counts and loads
// the window length with 25; ring contents are not cleared and need no clearing pass.
`include "trailing_window_std_dev_top_assert.svh"

module trailing_window_std_dev_top #(
  parameter int CHANNELS    = 3,
  parameter int RING_DEPTH  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [twd_pkg::N_BITS-1:0]            cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [twd_pkg::CH_BITS-1:0]           in_channel,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [twd_pkg::CH_BITS-1:0]           out_channel,
  output logic [twd_pkg::N_BITS-1:0]            out_used_count,
  output logic signed [twd_pkg::OUT_BITS-1:0]   out_mean_q8,
  output logic [twd_pkg::OUT_BITS-1:0]          out_std_dev_q8
);

  twd_pkg::twd_cmd_t cmd;
  twd_pkg::twd_sts_t sts;

  // Sequencer.
  twd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  twd_dpath #(
    .CHANNELS    (CHANNELS),
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_channel    (out_channel),
    .out_used_count (out_used_count),
    .out_mean_q8    (out_mean_q8),
    .out_std_dev_q8 (out_std_dev_q8)
  );

  // A new result never overwrites one still waiting.
  `TWD_ASSERT_IMP(a_load_free, cmd.out_load, (!out_valid || out_ready))
  // Short windows report zero statistics.
  `TWD_ASSERT_IMP(a_short_zero, out_valid && out_used_count < 7'd2, out_mean_q8 == '0 && out_std_dev_q8 == '0)
  // Only one word is in flight.
  `TWD_ASSERT_NXT(a_one_word, (in_valid && in_ready), !in_ready)
  // Ready only while every unit is quiet.
  `TWD_ASSERT_IMP(a_idle_quiet, in_ready, (!sts.acc_busy && !sts.div_busy && !sts.sqrt_busy))

endmodule
